// ===== src/sba_pkg.sv =====
package sba_pkg;

    // Sizes of the chunk array and of one chunk's busy map
    localparam int MAX_CHUNKS           = 16;
    localparam int MAX_BLOCKS_PER_CHUNK = 64;

    localparam int CHUNK_W   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CNT_W     = $clog2(MAX_CHUNKS + 1);
    localparam int BLK_IDX_W = $clog2(MAX_BLOCKS_PER_CHUNK);

    // Field widths
    localparam int LOG_W  = 5;
    localparam int SIZE_W = 24;
    localparam int ADDR_W = 28;
    localparam int DATA_W = 32;
    localparam int PADDR_W = 4;
    localparam int REG_IDX_W = 2;

    localparam logic [LOG_W-1:0] LOG2_LIMIT = 5'd24;

    // Request codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_CHUNK_SIZE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN_BLOCK  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CHUNKS     = 2'd2;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TOO_BIG  = 2'd1,
        ST_NO_SPACE = 2'd2,
        ST_BAD_FREE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_SCAN
    } t_state;

    // Request broadcast from the controller to every cell
    typedef struct packed {
        logic               func;
        logic [LOG_W-1:0]   cls;
        logic [LOG_W-1:0]   clog;
        logic [CNT_W-1:0]   nch;
        logic [CHUNK_W-1:0] target;
        logic [SIZE_W-1:0]  off;
        logic               claim;
        logic [CHUNK_W-1:0] claim_idx;
    } t_bcast;

    // Scan beat handed from cell to cell
    typedef struct packed {
        logic                 tok;
        logic                 done;
        logic [BLK_IDX_W-1:0] blk;
        logic [CHUNK_W-1:0]   chunk;
        logic                 free_seen;
        logic [CHUNK_W-1:0]   free_idx;
        t_status              status;
    } t_carry;

    // Smallest k with 2^k >= v, zero for v of zero or one
    function automatic logic [LOG_W-1:0] ceil_log2(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] m;
        logic [LOG_W-1:0]  k;
        m = v - SIZE_W'(1);
        k = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (m[i]) begin
                k = LOG_W'(i + 1);
            end
        end
        if (v <= SIZE_W'(1)) begin
            k = '0;
        end
        return k;
    endfunction

    // log2 of blocks in a chunk before the cap
    function automatic logic [LOG_W-1:0] blk_log2(input logic [LOG_W-1:0] cls,
                                                  input logic [LOG_W-1:0] clog);
        return (cls >= clog) ? '0 : (clog - cls);
    endfunction

endpackage

// ===== src/sba_cell.sv =====
module sba_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [sba_pkg::CHUNK_W-1:0] i_idx,
    input  sba_pkg::t_bcast          i_bc,
    input  sba_pkg::t_carry          i_carry,
    output sba_pkg::t_carry          o_carry
);

    logic                                   r_assigned;
    logic [sba_pkg::LOG_W-1:0]              r_cls;
    logic [sba_pkg::MAX_BLOCKS_PER_CHUNK-1:0] r_map;
    sba_pkg::t_carry                        r_carry;

    logic                                   n_assigned;
    logic [sba_pkg::LOG_W-1:0]              n_cls;
    logic [sba_pkg::MAX_BLOCKS_PER_CHUNK-1:0] n_map;
    sba_pkg::t_carry                        n_carry;

    logic                                   in_range;
    logic                                   act;
    logic [sba_pkg::LOG_W-1:0]              d_alloc;
    logic [sba_pkg::LOG_W-1:0]              d_free;
    logic [sba_pkg::MAX_BLOCKS_PER_CHUNK-1:0] free_vec;
    logic [sba_pkg::BLK_IDX_W-1:0]          first_free;
    logic                                   hit;
    logic                                   fhit;
    logic [sba_pkg::SIZE_W-1:0]             b_raw;
    logic                                   bad;

    // Find the lowest free block within the class's block count
    always_comb begin
        in_range = (sba_pkg::CNT_W'(i_idx) < i_bc.nch);
        act      = i_carry.tok && !i_carry.done && in_range;
        d_alloc  = sba_pkg::blk_log2(i_bc.cls, i_bc.clog);
        for (int j = 0; j < sba_pkg::MAX_BLOCKS_PER_CHUNK; j++) begin
            free_vec[j] = !r_map[j] && ((32'(j) >> d_alloc) == 32'd0);
        end
        first_free = '0;
        for (int j = sba_pkg::MAX_BLOCKS_PER_CHUNK - 1; j >= 0; j--) begin
            if (free_vec[j]) begin
                first_free = sba_pkg::BLK_IDX_W'(j);
            end
        end
        hit = act && (i_bc.func == sba_pkg::FUNC_ALLOC) && r_assigned
              && (r_cls == i_bc.cls) && (|free_vec);
    end

    // Check the block index of a free request against this chunk
    always_comb begin
        fhit   = act && (i_bc.func == sba_pkg::FUNC_FREE) && (i_idx == i_bc.target);
        d_free = sba_pkg::blk_log2(r_cls, i_bc.clog);
        b_raw  = i_bc.off >> r_cls;
        bad    = !r_assigned || ((b_raw >> d_free) != '0)
                 || (32'(b_raw) >= sba_pkg::MAX_BLOCKS_PER_CHUNK);
    end

    // Update chunk state and the outgoing beat
    always_comb begin
        n_assigned = r_assigned;
        n_cls      = r_cls;
        n_map      = r_map;
        n_carry    = i_carry;
        if (hit) begin
            n_map[first_free] = 1'b1;
            n_carry.done      = 1'b1;
            n_carry.blk       = first_free;
            n_carry.chunk     = i_idx;
        end
        if (act && (i_bc.func == sba_pkg::FUNC_ALLOC) && !r_assigned
                && !i_carry.free_seen) begin
            n_carry.free_seen = 1'b1;
            n_carry.free_idx  = i_idx;
        end
        if (fhit) begin
            n_carry.done = 1'b1;
            if (bad) begin
                n_carry.status = sba_pkg::ST_BAD_FREE;
            end else begin
                n_carry.status = sba_pkg::ST_OK;
                n_map[b_raw[sba_pkg::BLK_IDX_W-1:0]] = 1'b0;
            end
        end
        if (i_bc.claim && (i_bc.claim_idx == i_idx)) begin
            n_assigned = 1'b1;
            n_cls      = i_bc.cls;
            n_map      = sba_pkg::MAX_BLOCKS_PER_CHUNK'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_assigned  <= 1'b0;
            r_cls       <= '0;
            r_map       <= '0;
            r_carry     <= '0;
        end else begin
            r_assigned  <= n_assigned;
            r_cls       <= n_cls;
            r_map       <= n_map;
            r_carry     <= n_carry;
        end
    end

    assign o_carry = r_carry;

endmodule

// ===== src/sba_ctrl.sv =====
module sba_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_func,
    input  logic [sba_pkg::SIZE_W-1:0]    i_request_size,
    input  logic [sba_pkg::SIZE_W-1:0]    i_alignment,
    input  logic [sba_pkg::ADDR_W-1:0]    i_free_address,
    input  logic [sba_pkg::LOG_W-1:0]     i_clog,
    input  logic [sba_pkg::LOG_W-1:0]     i_mlog,
    input  logic [sba_pkg::CNT_W-1:0]     i_nch,
    input  sba_pkg::t_carry               i_chain,
    output sba_pkg::t_carry               o_launch,
    output sba_pkg::t_bcast               o_bc,
    output logic                          o_busy,
    output logic                          o_result_valid,
    output logic [sba_pkg::ADDR_W-1:0]    o_block_address,
    output logic [1:0]                    o_status
);

    sba_pkg::t_state                r_state, n_state;
    logic                           r_func, n_func;
    logic [sba_pkg::LOG_W-1:0]      r_cls, n_cls;
    logic [sba_pkg::ADDR_W-1:0]     r_faddr, n_faddr;
    logic [sba_pkg::CHUNK_W-1:0]    r_target, n_target;
    logic [sba_pkg::SIZE_W-1:0]     r_off, n_off;
    logic                           r_launch, n_launch;
    logic                           r_valid, n_valid;
    logic [sba_pkg::ADDR_W-1:0]     r_addr, n_addr;
    sba_pkg::t_status               r_status, n_status;

    logic [sba_pkg::SIZE_W-1:0]     eff_size;
    logic [sba_pkg::LOG_W-1:0]      raw_cls;
    logic [sba_pkg::ADDR_W-1:0]     fchunk;
    logic [sba_pkg::ADDR_W-1:0]     off_mask;
    logic                           claim;

    // Size class of the incoming request
    always_comb begin
        eff_size = (i_alignment > i_request_size) ? i_alignment : i_request_size;
        raw_cls  = sba_pkg::ceil_log2(eff_size);
        fchunk   = r_faddr >> i_clog;
        off_mask = (sba_pkg::ADDR_W'(1) << i_clog) - sba_pkg::ADDR_W'(1);
    end

    // Next state and results
    always_comb begin
        n_state  = r_state;
        n_func   = r_func;
        n_cls    = r_cls;
        n_faddr  = r_faddr;
        n_target = r_target;
        n_off    = r_off;
        n_launch = 1'b0;
        n_valid  = 1'b0;
        n_addr   = r_addr;
        n_status = r_status;
        claim    = 1'b0;
        unique case (r_state)
            sba_pkg::S_IDLE: begin
                if (i_start) begin
                    n_func  = i_func;
                    n_cls   = (raw_cls < i_mlog) ? i_mlog : raw_cls;
                    n_faddr = i_free_address;
                    n_state = sba_pkg::S_PREP;
                end
            end
            sba_pkg::S_PREP: begin
                n_addr = '0;
                if (r_func == sba_pkg::FUNC_ALLOC) begin
                    if (r_cls > i_clog) begin
                        n_status = sba_pkg::ST_TOO_BIG;
                        n_valid  = 1'b1;
                        n_state  = sba_pkg::S_IDLE;
                    end else begin
                        n_launch = 1'b1;
                        n_state  = sba_pkg::S_SCAN;
                    end
                end else begin
                    if (fchunk >= sba_pkg::ADDR_W'(i_nch)) begin
                        n_status = sba_pkg::ST_BAD_FREE;
                        n_valid  = 1'b1;
                        n_state  = sba_pkg::S_IDLE;
                    end else begin
                        n_target = fchunk[sba_pkg::CHUNK_W-1:0];
                        n_off    = sba_pkg::SIZE_W'(r_faddr & off_mask);
                        n_launch = 1'b1;
                        n_state  = sba_pkg::S_SCAN;
                    end
                end
            end
            sba_pkg::S_SCAN: begin
                if (i_chain.tok) begin
                    n_valid = 1'b1;
                    n_state = sba_pkg::S_IDLE;
                    if (r_func == sba_pkg::FUNC_FREE) begin
                        n_status = i_chain.status;
                    end else if (i_chain.done) begin
                        n_status = sba_pkg::ST_OK;
                        n_addr   = (sba_pkg::ADDR_W'(i_chain.chunk) << i_clog)
                                 | (sba_pkg::ADDR_W'(i_chain.blk) << r_cls);
                    end else if (i_chain.free_seen) begin
                        claim    = 1'b1;
                        n_status = sba_pkg::ST_OK;
                        n_addr   = sba_pkg::ADDR_W'(i_chain.free_idx) << i_clog;
                    end else begin
                        n_status = sba_pkg::ST_NO_SPACE;
                    end
                end
            end
            default: begin
                n_state = sba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sba_pkg::S_IDLE;
            r_launch <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= n_launch;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_cls    <= n_cls;
        r_faddr  <= n_faddr;
        r_target <= n_target;
        r_off    <= n_off;
        r_addr   <= n_addr;
        r_status <= n_status;
    end

    // Drive the chain head and the broadcast
    always_comb begin
        o_launch           = '0;
        o_launch.tok       = r_launch;
        o_launch.status    = sba_pkg::ST_OK;
        o_bc.func          = r_func;
        o_bc.cls           = r_cls;
        o_bc.clog          = i_clog;
        o_bc.nch           = i_nch;
        o_bc.target        = r_target;
        o_bc.off           = r_off;
        o_bc.claim         = claim;
        o_bc.claim_idx     = i_chain.free_idx;
    end

    assign o_busy          = (r_state != sba_pkg::S_IDLE);
    assign o_result_valid  = r_valid;
    assign o_block_address = r_addr;
    assign o_status        = r_status;

`ifndef SYNTHESIS
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe held longer than one cycle");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == sba_pkg::S_IDLE))
        else $error("result issued while a request is still in work");

    a_tok_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_chain.tok |-> (r_state == sba_pkg::S_SCAN))
        else $error("scan beat left the chain outside a scan");

    a_claim_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        claim |-> (r_func == sba_pkg::FUNC_ALLOC && !i_chain.done && i_chain.free_seen))
        else $error("chunk claimed without a miss and a free chunk");
`endif

endmodule

// ===== src/size_class_block_allocator.sv =====
// A scanning request passes the prep state, the launch register and each cell's
// register before the result strobe; oversize allocates and out-of-range frees
// answer from the prep state. Requests are taken only while idle, and the beat walks
// the 16-cell chain one cell per cycle, and busy drops in the cycle the result shows.
// Reset (synchronous, active low) frees all chunks and loads the register defaults;
// the result strobe lasts one cycle and the receiver cannot stall it.
module size_class_block_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_func,
    input  logic [sba_pkg::SIZE_W-1:0]    i_request_size,
    input  logic [sba_pkg::SIZE_W-1:0]    i_alignment,
    input  logic [sba_pkg::ADDR_W-1:0]    i_free_address,
    output logic                          o_result_valid,
    output logic [sba_pkg::ADDR_W-1:0]    o_block_address,
    output logic [1:0]                    o_status,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sba_pkg::PADDR_W-1:0]   paddr,
    input  logic [sba_pkg::DATA_W-1:0]    pwdata,
    output logic [sba_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    logic [sba_pkg::LOG_W-1:0]  r_chunk_size_log2;
    logic [sba_pkg::LOG_W-1:0]  r_min_block_log2;
    logic [sba_pkg::LOG_W-1:0]  r_chunks_in_use;

    logic                       cfg_wr;
    logic [sba_pkg::REG_IDX_W-1:0] reg_idx;
    logic [sba_pkg::LOG_W-1:0]  clog;
    logic [sba_pkg::LOG_W-1:0]  mlog;
    logic [sba_pkg::CNT_W-1:0]  nch;

    sba_pkg::t_bcast            bc;
    sba_pkg::t_carry            chain [sba_pkg::MAX_CHUNKS+1];

    // Register writes on the access beat
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[sba_pkg::PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_size_log2 <= 5'd12;
            r_min_block_log2  <= 5'd4;
            r_chunks_in_use   <= 5'd16;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                sba_pkg::REG_CHUNK_SIZE: r_chunk_size_log2 <= pwdata[sba_pkg::LOG_W-1:0];
                sba_pkg::REG_MIN_BLOCK:  r_min_block_log2  <= pwdata[sba_pkg::LOG_W-1:0];
                sba_pkg::REG_CHUNKS:     r_chunks_in_use   <= pwdata[sba_pkg::LOG_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (reg_idx)
            sba_pkg::REG_CHUNK_SIZE: prdata = sba_pkg::DATA_W'(r_chunk_size_log2);
            sba_pkg::REG_MIN_BLOCK:  prdata = sba_pkg::DATA_W'(r_min_block_log2);
            sba_pkg::REG_CHUNKS:     prdata = sba_pkg::DATA_W'(r_chunks_in_use);
            default:                 prdata = '0;
        endcase
    end

    // Saturate the log2 fields and clamp the chunk count
    always_comb begin
        clog = (r_chunk_size_log2 > sba_pkg::LOG2_LIMIT) ? sba_pkg::LOG2_LIMIT
                                                         : r_chunk_size_log2;
        mlog = (r_min_block_log2 > sba_pkg::LOG2_LIMIT) ? sba_pkg::LOG2_LIMIT
                                                        : r_min_block_log2;
        nch  = (32'(r_chunks_in_use) > sba_pkg::MAX_CHUNKS)
               ? sba_pkg::CNT_W'(sba_pkg::MAX_CHUNKS)
               : sba_pkg::CNT_W'(r_chunks_in_use);
    end

    sba_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_func          (i_func),
        .i_request_size  (i_request_size),
        .i_alignment     (i_alignment),
        .i_free_address  (i_free_address),
        .i_clog          (clog),
        .i_mlog          (mlog),
        .i_nch           (nch),
        .i_chain         (chain[sba_pkg::MAX_CHUNKS]),
        .o_launch        (chain[0]),
        .o_bc            (bc),
        .o_busy          (busy),
        .o_result_valid  (o_result_valid),
        .o_block_address (o_block_address),
        .o_status        (o_status)
    );

    // One cell per chunk, the scan beat moving one cell per cycle
    for (genvar g = 0; g < sba_pkg::MAX_CHUNKS; g++) begin : g_cell
        sba_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (sba_pkg::CHUNK_W'(g)),
            .i_bc    (bc),
            .i_carry (chain[g]),
            .o_carry (chain[g+1])
        );
    end

endmodule
